// File: rtl/core/obbsat_pkg.sv
// Package for the oriented box overlap test: sizes, widths, latency and the
// quarter-wave sine table builder. No dependencies; used by every core file.
package obbsat_pkg;

    localparam int COORD_BITS     = 16;
    localparam int ANGLE_BITS     = 12;
    localparam int TRIG_FRAC_BITS = 15;

    // Derived widths.
    localparam int LW      = COORD_BITS - 1;        // box extent
    localparam int DW      = COORD_BITS + 1;        // center offset
    localparam int TW      = TRIG_FRAC_BITS + 2;    // signed sine / cosine
    localparam int PW      = DW + TW;               // offset times trig
    localparam int PSW     = PW + 1;                // sum of two such products
    localparam int TPW     = 2 * TW;                // trig times trig
    localparam int MW      = TPW + 1;               // sum of two trig products
    localparam int DSW     = PSW + TRIG_FRAC_BITS + 1;  // scaled projection
    localparam int EW      = LW + MW;               // extent times trig sum
    localparam int RW      = EW + 2;                // sum of three extents
    localparam int CMPW    = (DSW > RW) ? DSW : RW;
    localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
    localparam int IDXW    = ANGLE_BITS - 1;
    localparam int LATENCY = 5;

    localparam longint unsigned HALF_PI_Q48 = 64'h0001_921F_B544_42D2;

    typedef logic [TRIG_FRAC_BITS:0] sin_mag_t;
    typedef sin_mag_t sin_tab_t [0:QUARTER];

    // Restoring shift and subtract quotient; only used while the table is built.
    function automatic longint unsigned series_div(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned quo;
        longint unsigned part;
        quo  = 64'd0;
        part = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            part = {part[62:0], num[i]};
            quo  = quo << 1;
            if (part >= den)
            begin
                part   = part - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine of k quarter steps by a Q30 Taylor series, rounded to the trig format.
    function automatic sin_mag_t quarter_sin(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        int unsigned     sh;
        int unsigned     rs;
        sh   = 18 + ANGLE_BITS - 2;
        rs   = 30 - TRIG_FRAC_BITS;
        x    = (k * HALF_PI_Q48 + (64'd1 << (sh - 1))) >> sh;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 13; n++)
        begin
            term = series_div((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
            if ((n % 2) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (longint'(sum) + (64'd1 << (rs - 1))) >> rs;
        if (v > (64'd1 << TRIG_FRAC_BITS))
        begin
            v = 64'd1 << TRIG_FRAC_BITS;
        end
        return sin_mag_t'(v);
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t t;
        for (int k = 0; k <= QUARTER; k++)
        begin
            t[k] = quarter_sin(longint'(k));
        end
        return t;
    endfunction

endpackage

// File: rtl/core/oriented_box_overlap_test_top.sv
// Top level of the oriented box overlap test (separating axis test, two boxes).
// Depends on obbsat_pkg and obbsat_trig.
//
// One box pair is taken in every cycle that start is high (busy is always low),
// and its result appears on boxes_overlap with done high once it has passed
// the five stages: the table lookup, the trig and offset products, their sums
// and magnitudes, the extent products and the final sums and compares. The
// receiver cannot stall; results come out in input order.
module oriented_box_overlap_test_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  a_center_x,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  a_center_y,
    input  logic [obbsat_pkg::LW-1:0]                 a_width,
    input  logic [obbsat_pkg::LW-1:0]                 a_height,
    input  logic [obbsat_pkg::ANGLE_BITS-1:0]         a_angle,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  b_center_x,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  b_center_y,
    input  logic [obbsat_pkg::LW-1:0]                 b_width,
    input  logic [obbsat_pkg::LW-1:0]                 b_height,
    input  logic [obbsat_pkg::ANGLE_BITS-1:0]         b_angle,
    output logic                                      done,
    output logic                                      boxes_overlap
);

    localparam int LW   = obbsat_pkg::LW;
    localparam int DW   = obbsat_pkg::DW;
    localparam int TW   = obbsat_pkg::TW;
    localparam int PW   = obbsat_pkg::PW;
    localparam int PSW  = obbsat_pkg::PSW;
    localparam int TPW  = obbsat_pkg::TPW;
    localparam int MW   = obbsat_pkg::MW;
    localparam int EW   = obbsat_pkg::EW;
    localparam int RW   = obbsat_pkg::RW;
    localparam int CMPW = obbsat_pkg::CMPW;
    localparam int FS   = obbsat_pkg::TRIG_FRAC_BITS + 1;

    typedef logic [LW-1:0] len_t;
    typedef struct packed {
        len_t aw;
        len_t ah;
        len_t bw;
        len_t bh;
    } dims_t;

    // Valid chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1: table lookup, offsets.
    logic signed [TW-1:0] sa, ca, sb, cb;
    logic signed [DW-1:0] dx_reg, dy_reg;
    dims_t                d1_reg, d2_reg, d3_reg;

    // Stage 2: products.
    logic signed [TPW-1:0] cc_reg, ss_reg, sc_reg, cs_reg;
    logic signed [TPW-1:0] ca2_reg, sa2_reg, cb2_reg, sb2_reg;
    logic signed [PW-1:0]  dxca_reg, dysa_reg, dxsa_reg, dyca_reg;
    logic signed [PW-1:0]  dxcb_reg, dysb_reg, dxsb_reg, dycb_reg;

    // Stage 3: sums and magnitudes.
    logic signed [MW-1:0]  c_sum, s_sum;
    logic signed [PSW-1:0] pa1_sum, pa2_sum, pb1_sum, pb2_sum;
    logic [MW-1:0]         c_mag_reg, s_mag_reg, na_reg, nb_reg;
    logic [PSW-1:0]        pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic [PSW-1:0]        pa1_q4_reg, pa2_q4_reg, pb1_q4_reg, pb2_q4_reg;

    // Stage 4: extent products.
    logic [EW-1:0] awn_reg, ahn_reg, bwn_reg, bhn_reg;
    logic [EW-1:0] bwc_reg, bhs_reg, bws_reg, bhc_reg;
    logic [EW-1:0] awc_reg, ahs_reg, aws_reg, ahc_reg;

    // Stage 5: compares.
    logic [RW-1:0]   r1, r2, r3, r4;
    logic [CMPW-1:0] q1, q2, q3, q4;
    logic            overlap_next;
    logic            overlap_reg;

    assign busy = 1'b0;

    obbsat_trig u_trig_a (
        .clk     (clk),
        .angle   (a_angle),
        .sin_val (sa),
        .cos_val (ca)
    );

    obbsat_trig u_trig_b (
        .clk     (clk),
        .angle   (b_angle),
        .sin_val (sb),
        .cos_val (cb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= DW'(b_center_x) - DW'(a_center_x);
        dy_reg <= DW'(b_center_y) - DW'(a_center_y);
        d1_reg <= '{aw: a_width, ah: a_height, bw: b_width, bh: b_height};
        d2_reg <= d1_reg;
        d3_reg <= d2_reg;
    end

    always_ff @(posedge clk)
    begin
        cc_reg   <= ca * cb;
        ss_reg   <= sa * sb;
        sc_reg   <= sa * cb;
        cs_reg   <= ca * sb;
        ca2_reg  <= ca * ca;
        sa2_reg  <= sa * sa;
        cb2_reg  <= cb * cb;
        sb2_reg  <= sb * sb;
        dxca_reg <= PW'(dx_reg) * PW'(ca);
        dysa_reg <= PW'(dy_reg) * PW'(sa);
        dxsa_reg <= PW'(dx_reg) * PW'(sa);
        dyca_reg <= PW'(dy_reg) * PW'(ca);
        dxcb_reg <= PW'(dx_reg) * PW'(cb);
        dysb_reg <= PW'(dy_reg) * PW'(sb);
        dxsb_reg <= PW'(dx_reg) * PW'(sb);
        dycb_reg <= PW'(dy_reg) * PW'(cb);
    end

    // The relative rotation's cosine and sine serve all four axes; only
    // their magnitudes matter.
    assign c_sum   = MW'(cc_reg) + MW'(ss_reg);
    assign s_sum   = MW'(sc_reg) - MW'(cs_reg);
    assign pa1_sum = PSW'(dxca_reg) + PSW'(dysa_reg);
    assign pa2_sum = PSW'(dyca_reg) - PSW'(dxsa_reg);
    assign pb1_sum = PSW'(dxcb_reg) + PSW'(dysb_reg);
    assign pb2_sum = PSW'(dycb_reg) - PSW'(dxsb_reg);

    always_ff @(posedge clk)
    begin
        c_mag_reg <= c_sum[MW-1] ? MW'(-c_sum) : MW'(c_sum);
        s_mag_reg <= s_sum[MW-1] ? MW'(-s_sum) : MW'(s_sum);
        na_reg    <= MW'(ca2_reg) + MW'(sa2_reg);
        nb_reg    <= MW'(cb2_reg) + MW'(sb2_reg);
        pa1_reg   <= pa1_sum[PSW-1] ? PSW'(-pa1_sum) : PSW'(pa1_sum);
        pa2_reg   <= pa2_sum[PSW-1] ? PSW'(-pa2_sum) : PSW'(pa2_sum);
        pb1_reg   <= pb1_sum[PSW-1] ? PSW'(-pb1_sum) : PSW'(pb1_sum);
        pb2_reg   <= pb2_sum[PSW-1] ? PSW'(-pb2_sum) : PSW'(pb2_sum);
    end

    always_ff @(posedge clk)
    begin
        awn_reg    <= EW'(d3_reg.aw) * EW'(na_reg);
        ahn_reg    <= EW'(d3_reg.ah) * EW'(na_reg);
        bwn_reg    <= EW'(d3_reg.bw) * EW'(nb_reg);
        bhn_reg    <= EW'(d3_reg.bh) * EW'(nb_reg);
        bwc_reg    <= EW'(d3_reg.bw) * EW'(c_mag_reg);
        bhs_reg    <= EW'(d3_reg.bh) * EW'(s_mag_reg);
        bws_reg    <= EW'(d3_reg.bw) * EW'(s_mag_reg);
        bhc_reg    <= EW'(d3_reg.bh) * EW'(c_mag_reg);
        awc_reg    <= EW'(d3_reg.aw) * EW'(c_mag_reg);
        ahs_reg    <= EW'(d3_reg.ah) * EW'(s_mag_reg);
        aws_reg    <= EW'(d3_reg.aw) * EW'(s_mag_reg);
        ahc_reg    <= EW'(d3_reg.ah) * EW'(c_mag_reg);
        pa1_q4_reg <= pa1_reg;
        pa2_q4_reg <= pa2_reg;
        pb1_q4_reg <= pb1_reg;
        pb2_q4_reg <= pb2_reg;
    end

    assign r1 = RW'(awn_reg) + RW'(bwc_reg) + RW'(bhs_reg);
    assign r2 = RW'(ahn_reg) + RW'(bws_reg) + RW'(bhc_reg);
    assign r3 = RW'(bwn_reg) + RW'(awc_reg) + RW'(ahs_reg);
    assign r4 = RW'(bhn_reg) + RW'(aws_reg) + RW'(ahc_reg);

    // The center projections carry the same scale as the extents once
    // shifted up by the trig fraction plus one.
    assign q1 = CMPW'(pa1_q4_reg) << FS;
    assign q2 = CMPW'(pa2_q4_reg) << FS;
    assign q3 = CMPW'(pb1_q4_reg) << FS;
    assign q4 = CMPW'(pb2_q4_reg) << FS;

    assign overlap_next = !((q1 > CMPW'(r1)) || (q2 > CMPW'(r2)) ||
                            (q3 > CMPW'(r3)) || (q4 > CMPW'(r4)));

    always_ff @(posedge clk)
    begin
        overlap_reg <= overlap_next;
    end

    assign done          = v5_reg;
    assign boxes_overlap = overlap_reg;

endmodule

// File: rtl/core/obbsat_trig.sv
// Sine and cosine of a binary angle from a registered quarter-wave table.
// Depends on obbsat_pkg for widths and the table contents.
module obbsat_trig (
    input  logic                                     clk,
    input  logic [obbsat_pkg::ANGLE_BITS-1:0]        angle,
    output logic signed [obbsat_pkg::TW-1:0]         sin_val,
    output logic signed [obbsat_pkg::TW-1:0]         cos_val
);

    localparam obbsat_pkg::sin_tab_t SIN_ROM = obbsat_pkg::build_sin_tab();
    localparam int AB = obbsat_pkg::ANGLE_BITS;

    logic [AB-1:0]               cos_angle;
    logic [obbsat_pkg::IDXW-1:0] sin_idx;
    logic [obbsat_pkg::IDXW-1:0] cos_idx;
    obbsat_pkg::sin_mag_t        sin_mag_reg;
    obbsat_pkg::sin_mag_t        cos_mag_reg;
    logic                        sin_neg_reg;
    logic                        cos_neg_reg;

    assign cos_angle = angle + AB'(obbsat_pkg::QUARTER);

    // Odd quadrants read the table mirrored; the upper half of the turn negates.
    assign sin_idx = angle[AB-2] ?
        (obbsat_pkg::IDXW'(obbsat_pkg::QUARTER) - {1'b0, angle[AB-3:0]}) :
        {1'b0, angle[AB-3:0]};
    assign cos_idx = cos_angle[AB-2] ?
        (obbsat_pkg::IDXW'(obbsat_pkg::QUARTER) - {1'b0, cos_angle[AB-3:0]}) :
        {1'b0, cos_angle[AB-3:0]};

    always_ff @(posedge clk)
    begin
        sin_mag_reg <= SIN_ROM[sin_idx];
        cos_mag_reg <= SIN_ROM[cos_idx];
        sin_neg_reg <= angle[AB-1];
        cos_neg_reg <= cos_angle[AB-1];
    end

    assign sin_val = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
    assign cos_val = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});

endmodule

// File: rtl/core/obbsat_checker.sv
// Port-level checks for the oriented box overlap test and the bind that
// attaches them to the top level. Depends on obbsat_pkg for the latency.
module obbsat_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic boxes_overlap
);

    localparam int LAT = obbsat_pkg::LATENCY;

    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline never stalls");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transfer produced no result at the fixed latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(boxes_overlap))
        else $error("result transfer carries an unknown overlap flag");

endmodule

bind oriented_box_overlap_test_top obbsat_checker u_obbsat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .boxes_overlap (boxes_overlap)
);

// File: test/obbsat_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the oriented box overlap test: watches the command and result
// ports, predicts each overlap flag and compares. Depends on obbsat_pkg only.
module obbsat_scoreboard (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic                                      busy,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  a_center_x,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  a_center_y,
    input  logic [obbsat_pkg::LW-1:0]                 a_width,
    input  logic [obbsat_pkg::LW-1:0]                 a_height,
    input  logic [obbsat_pkg::ANGLE_BITS-1:0]         a_angle,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  b_center_x,
    input  logic signed [obbsat_pkg::COORD_BITS-1:0]  b_center_y,
    input  logic [obbsat_pkg::LW-1:0]                 b_width,
    input  logic [obbsat_pkg::LW-1:0]                 b_height,
    input  logic [obbsat_pkg::ANGLE_BITS-1:0]         b_angle,
    input  logic                                      done,
    input  logic                                      boxes_overlap,
    output int                                        errors,
    output int                                        pending,
    output int                                        overlaps_seen,
    output int                                        results_seen
);
    localparam int ANGLE_BITS     = obbsat_pkg::ANGLE_BITS;
    localparam int TRIG_FRAC_BITS = obbsat_pkg::TRIG_FRAC_BITS;
    localparam int QUARTER        = obbsat_pkg::QUARTER;

    localparam longint unsigned PI_HALF_Q48 = 64'h0001_921F_B544_42D2;

    longint sine_mag [0:QUARTER];
    bit     overlap_fifo [$];

    // Series for sin in Q30, then rounded half up to the trig format.
    function automatic longint sine_step(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint unsigned r;
        x    = (k * PI_HALF_Q48 + (64'd1 << (16 + ANGLE_BITS - 1))) >> (16 + ANGLE_BITS);
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 13; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (unsigned'(acc) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        if (r > (64'd1 << TRIG_FRAC_BITS))
        begin
            r = 64'd1 << TRIG_FRAC_BITS;
        end
        return longint'(r);
    endfunction

    function automatic longint angle_sine(input logic [ANGLE_BITS-1:0] ang);
        logic [1:0]            quad;
        logic [ANGLE_BITS-3:0] rem;
        longint                m;
        quad = ang[ANGLE_BITS-1 -: 2];
        rem  = ang[ANGLE_BITS-3:0];
        m    = quad[0] ? sine_mag[QUARTER - int'(rem)] : sine_mag[rem];
        return quad[1] ? -m : m;
    endfunction

    function automatic logic signed [127:0] mag128(input logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // Axis (ux,uy) of one box with its own extent len; the other box at (dx,dy).
    function automatic bit axis_separates(input longint ux, input longint uy,
                                          input longint len, input longint dx,
                                          input longint dy, input longint wr,
                                          input longint hr, input longint cr,
                                          input longint sr);
        logic signed [127:0] proj;
        logic signed [127:0] reach;
        logic signed [127:0] t;
        proj  = dx * ux + dy * uy;
        proj  = proj <<< (TRIG_FRAC_BITS + 1);
        reach = len;
        t     = ux * ux + uy * uy;
        reach = reach * t;
        t     = cr * ux + sr * uy;
        reach = reach + mag128(t * wr);
        t     = cr * uy - sr * ux;
        reach = reach + mag128(t * hr);
        return mag128(proj) > reach;
    endfunction

    function automatic bit predict_overlap();
        longint sa, ca, sb, cb, dx, dy;
        bit     sep;
        sa  = angle_sine(a_angle);
        ca  = angle_sine(ANGLE_BITS'(a_angle + QUARTER));
        sb  = angle_sine(b_angle);
        cb  = angle_sine(ANGLE_BITS'(b_angle + QUARTER));
        dx  = longint'(b_center_x) - longint'(a_center_x);
        dy  = longint'(b_center_y) - longint'(a_center_y);
        sep = axis_separates(ca, sa, a_width, dx, dy, b_width, b_height, cb, sb)
           || axis_separates(-sa, ca, a_height, dx, dy, b_width, b_height, cb, sb)
           || axis_separates(cb, sb, b_width, -dx, -dy, a_width, a_height, ca, sa)
           || axis_separates(-sb, cb, b_height, -dx, -dy, a_width, a_height, ca, sa);
        return !sep;
    endfunction

    initial
    begin
        for (int k = 0; k <= QUARTER; k++)
        begin
            sine_mag[k] = sine_step(longint'(k));
        end
        errors        = 0;
        overlaps_seen = 0;
        results_seen  = 0;
    end

    assign pending = overlap_fifo.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (overlap_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none, actual %0b",
                             $time, boxes_overlap);
                    errors <= errors + 1;
                end
                else
                begin
                    if (boxes_overlap !== overlap_fifo[0])
                    begin
                        $display("%0t: boxes_overlap mismatch, expected %0b, actual %0b",
                                 $time, overlap_fifo[0], boxes_overlap);
                        errors <= errors + 1;
                    end
                    void'(overlap_fifo.pop_front());
                end
                results_seen  <= results_seen + 1;
                overlaps_seen <= overlaps_seen + (boxes_overlap === 1'b1);
            end
            if (start && !busy)
            begin
                overlap_fifo.push_back(predict_overlap());
            end
        end
    end
endmodule

// File: test/tb_oriented_box_overlap_test_top.sv
`timescale 1ns / 1ps
// Testbench top for the oriented box overlap test: clock, reset, directed and
// random box pairs in bursts. Depends on obbsat_pkg, obbsat_scoreboard and the RTL.
module tb_oriented_box_overlap_test_top;
    localparam int COORD_BITS = obbsat_pkg::COORD_BITS;
    localparam int ANGLE_BITS = obbsat_pkg::ANGLE_BITS;
    localparam int LW         = obbsat_pkg::LW;
    localparam int LATENCY    = obbsat_pkg::LATENCY;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_PAIRS = 1930;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [COORD_BITS-1:0]  a_center_x, a_center_y, b_center_x, b_center_y;
    logic [LW-1:0]                 a_width, a_height, b_width, b_height;
    logic [ANGLE_BITS-1:0]         a_angle, b_angle;
    logic                          done;
    logic                          boxes_overlap;
    int                            errors, pending, overlaps_seen, results_seen;
    int                            cycles;
    int                            burst_left;

    oriented_box_overlap_test_top uut (.*);

    obbsat_scoreboard u_scoreboard (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drives one pair and returns once its transfer has happened; then maybe idles.
    task automatic send_pair(input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
                             input logic [LW-1:0] aw, input logic [LW-1:0] ah,
                             input logic [ANGLE_BITS-1:0] aa,
                             input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
                             input logic [LW-1:0] bw, input logic [LW-1:0] bh,
                             input logic [ANGLE_BITS-1:0] ba);
        int gap;
        a_center_x <= ax;
        a_center_y <= ay;
        a_width    <= aw;
        a_height   <= ah;
        a_angle    <= aa;
        b_center_x <= bx;
        b_center_y <= by;
        b_width    <= bw;
        b_height   <= bh;
        b_angle    <= ba;
        start      <= 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (busy);
        @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [LW-1:0] pick_extent(input int kind);
        if (kind < 6)
        begin
            return LW'($urandom_range(1, 200));
        end
        else if (kind < 9)
        begin
            return LW'($urandom_range(1, 4000));
        end
        return LW'($urandom_range(1, 32767));
    endfunction

    initial
    begin
        logic [COORD_BITS-1:0] ax, ay, bx, by;
        logic [LW-1:0]         aw, ah, bw, bh;
        int                    kind, span;
        cycles     = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        {a_center_x, a_center_y, b_center_x, b_center_y} = '0;
        {a_width, a_height, b_width, b_height} = '0;
        a_angle = '0;
        b_angle = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identical boxes, edges touching, one unit apart, and rotated variants.
        send_pair(0, 0, 10, 10, 0, 0, 0, 10, 10, 0);
        send_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0);
        send_pair(0, 0, 10, 10, 0, 11, 0, 10, 10, 0);
        send_pair(0, 0, 10, 10, 0, 0, 10, 10, 10, 0);
        send_pair(0, 0, 10, 10, 0, 0, 16'hFFF5, 10, 10, 0);
        send_pair(0, 0, 20, 2, 1024, 0, 10, 4, 4, 0);
        send_pair(0, 0, 20, 2, 2048, 12, 0, 4, 4, 3072);
        send_pair(0, 0, 100, 100, 512, 75, 75, 10, 10, 0);
        send_pair(0, 0, 100, 100, 512, 70, 0, 10, 10, 512);
        send_pair(0, 0, 1, 1, 4095, 1, 1, 1, 1, 1);
        send_pair(0, 0, 1, 1, 0, 2, 0, 1, 1, 0);
        // Extremes of every field.
        send_pair(16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 12'hFFF,
                  16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 12'h000);
        send_pair(16'h8000, 16'h8000, 1, 1, 0, 16'h7FFF, 16'h7FFF, 1, 1, 12'hFFF);
        send_pair(16'h7FFF, 16'h8000, 15'h7FFF, 1, 12'h400,
                  16'h8000, 16'h7FFF, 1, 15'h7FFF, 12'hC00);
        send_pair(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 12'h800,
                  0, 0, 15'h7FFF, 15'h7FFF, 12'h7FF);
        send_pair(0, 0, 15'h7FFF, 1, 12'h200, 16'h5A82, 16'h5A82, 1, 1, 0);

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            kind = $urandom_range(0, 9);
            aw = pick_extent(kind);
            ah = pick_extent(kind);
            bw = pick_extent(kind);
            bh = pick_extent(kind);
            ax = COORD_BITS'($urandom);
            ay = COORD_BITS'($urandom);
            if ($urandom_range(0, 7) == 0)
            begin
                bx = COORD_BITS'($urandom);
                by = COORD_BITS'($urandom);
            end
            else
            begin
                // Offsets within three eighths of the summed extents, so both outcomes are common.
                span = (int'(aw) + int'(ah) + int'(bw) + int'(bh)) * 3 / 8 + 1;
                bx = ax + COORD_BITS'($urandom_range(0, 2 * span) - span);
                by = ay + COORD_BITS'($urandom_range(0, 2 * span) - span);
            end
            send_pair(ax, ay, aw, ah, ANGLE_BITS'($urandom), bx, by, bw, bh,
                      ANGLE_BITS'($urandom));
        end
        start <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 5) @(posedge clk);
        $display("Checked %0d box pairs, %0d of them overlapping, with random gaps.",
                 results_seen, overlaps_seen);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
